// ===== design/lmmd_pkg.sv =====
package lmmd_pkg;

  // Store geometry: 16 grid columns, two extra columns, 17 rows each
  localparam int unsigned STORE_ROWS  = 17;
  localparam int unsigned STORE_DEPTH = 306;
  localparam int unsigned ADDR_W      = 9;
  localparam logic [4:0]  XCOL        = 5'd16;
  localparam logic [4:0]  XROW        = 5'd16;

  // SysEx bytes
  localparam logic [7:0] SYX_START  = 8'hf0;
  localparam logic [7:0] SYX_END    = 8'hf7;
  localparam logic [7:0] SYX_UNIV   = 8'h7e;
  localparam logic [7:0] SYX_FAMILY = 8'h4e;
  localparam logic [7:0] SYX_ACK    = 8'h0f;
  localparam logic [7:0] SYX_LAYOUT = 8'h01;

  // MIDI events
  localparam logic [3:0] EV_NOTE_OFF = 4'h8;
  localparam logic [3:0] EV_NOTE_ON  = 4'h9;
  localparam logic [3:0] EV_CTRL     = 4'hb;
  localparam logic [3:0] EV_SYSTEM   = 4'hf;

  // Result kinds
  localparam logic [1:0] KIND_GRID  = 2'd0;
  localparam logic [1:0] KIND_XCOL  = 2'd1;
  localparam logic [1:0] KIND_XROW  = 2'd2;
  localparam logic [1:0] KIND_REPLY = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FORWARD   = 1'b0;
  localparam logic CFG_ROW_COUNT = 1'b1;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_READY_ONLY,
    CLS_CELLS,
    CLS_REPLY
  } cls_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_WRITE,
    ST_DONE,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic decode;
    logic cell_rd;
    logic cell_wr;
    logic rep_emit;
    logic set_ready;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    cls_t cls;
    logic cell_last;
    logic cell_emit;
    logic out_free;
    logic rep_last;
  } sts_t;

endpackage

// ===== design/led_matrix_midi_decoder_top.sv =====
// One message at a time: a note write reads its store cell and then writes it; an eight-cell
// controller pattern does a store read then a write for each of its cells, in turn.
// A SysEx reply goes out at one word per cycle while the output is free, 9 or 14 words.
// Each cell write waits on a registered store read, and a stalled output holds the write.
// Reset is synchronous; after it a pass clears all 306 cells of the store,
// during which no message is taken (configuration writes are).
module led_matrix_midi_decoder_top #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // status_byte, first_data, second_data, sysex_byte_3..7, msg_length
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // led_col[3:0], led_row[7:4], led_state[9:8], reply_byte[17:10], ready_flag[18]
  output logic [23:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  lmmd_pkg::cmd_t cmd;
  lmmd_pkg::sts_t sts;

  lmmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmmd_datapath #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== design/lmmd_ram.sv =====
module lmmd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 306
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lmmd_ctrl.sv =====
module lmmd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  lmmd_pkg::sts_t  sts,
  output lmmd_pkg::cmd_t  cmd
);

  lmmd_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmmd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lmmd_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_next = lmmd_pkg::ST_IDLE;
      end
      lmmd_pkg::ST_IDLE: begin
        if (in_valid) state_next = lmmd_pkg::ST_LOAD;
      end
      lmmd_pkg::ST_LOAD: begin
        case (sts.cls)
          lmmd_pkg::CLS_CELLS:      state_next = lmmd_pkg::ST_READ;
          lmmd_pkg::CLS_REPLY:      state_next = lmmd_pkg::ST_REPLY;
          lmmd_pkg::CLS_READY_ONLY: state_next = lmmd_pkg::ST_DONE;
          default:                  state_next = lmmd_pkg::ST_IDLE;
        endcase
      end
      lmmd_pkg::ST_READ: state_next = lmmd_pkg::ST_WRITE;
      lmmd_pkg::ST_WRITE: begin
        if (!sts.cell_emit || sts.out_free) begin
          state_next = sts.cell_last ? lmmd_pkg::ST_DONE : lmmd_pkg::ST_READ;
        end
      end
      lmmd_pkg::ST_DONE: state_next = lmmd_pkg::ST_IDLE;
      lmmd_pkg::ST_REPLY: begin
        if (sts.out_free && sts.rep_last) state_next = lmmd_pkg::ST_IDLE;
      end
      default: state_next = lmmd_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      lmmd_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
      lmmd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lmmd_pkg::ST_LOAD: begin
        cmd.decode    = 1'b1;
        cmd.set_ready = (sts.cls == lmmd_pkg::CLS_REPLY);
      end
      lmmd_pkg::ST_READ: cmd.cell_rd = 1'b1;
      lmmd_pkg::ST_WRITE: cmd.cell_wr = !sts.cell_emit || sts.out_free;
      lmmd_pkg::ST_DONE: cmd.set_ready = 1'b1;
      lmmd_pkg::ST_REPLY: cmd.rep_emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/lmmd_datapath.sv =====
module lmmd_datapath #(
  parameter int GRID_COLS = 16,
  parameter int GRID_ROWS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  lmmd_pkg::cmd_t  cmd,
  output lmmd_pkg::sts_t  sts,
  input  logic [71:0]     in_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [4:0]      cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [23:0]     out_data,
  output logic [1:0]      out_kind,
  output logic            out_last
);

  localparam logic [4:0] GC      = 5'(GRID_COLS);
  localparam logic [4:0] GR      = 5'(GRID_ROWS);
  localparam logic [7:0] GC_BYTE = 8'(GRID_COLS) & 8'h7f;
  localparam logic [lmmd_pkg::ADDR_W-1:0] CLR_LAST =
    lmmd_pkg::ADDR_W'(lmmd_pkg::STORE_DEPTH - 1);

  function automatic logic cell_ok(input logic [4:0] col, input logic [4:0] row);
    logic ok;
    ok = 1'b1;
    if (col > lmmd_pkg::XCOL + 5'd1 || row > lmmd_pkg::XROW) ok = 1'b0;
    else if (col < lmmd_pkg::XCOL && row < lmmd_pkg::XROW && (col >= GC || row >= GR))
      ok = 1'b0;
    return ok;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [3:0] k, input logic lay,
                                          input logic [4:0] rc);
    logic [7:0] b;
    case (k)
      4'd0:    b = lmmd_pkg::SYX_START;
      4'd3:    b = lmmd_pkg::SYX_UNIV;
      4'd4:    b = lmmd_pkg::SYX_FAMILY;
      4'd6:    b = lay ? lmmd_pkg::SYX_LAYOUT : lmmd_pkg::SYX_ACK;
      4'd7:    b = lay ? GC_BYTE : 8'h00;
      4'd8:    b = lay ? {3'b000, rc} : lmmd_pkg::SYX_END;
      4'd9:    b = 8'h02;
      4'd10, 4'd11, 4'd12: b = 8'h01;
      4'd13:   b = lmmd_pkg::SYX_END;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  logic [71:0] msg;
  logic        fwd;
  logic [4:0]  row_count;
  logic        ready_flag;
  logic [lmmd_pkg::ADDR_W-1:0] clr_cnt;
  logic [3:0]  step;

  // Decoded message
  logic [4:0] base_col, base_row;
  logic       horiz, multi, lay;
  logic [1:0] keep, mset;
  logic [7:0] pat;

  logic [4:0] d_col, d_row;
  logic       d_horiz, d_multi, d_bit, d_hit;
  logic [1:0] d_st;
  lmmd_pkg::cls_t d_cls;

  logic [7:0] b0, b1, b2;
  logic [3:0] ev, ch;
  logic       syx_match, syx_lay, syx_ack;

  assign b0 = msg[7:0];
  assign b1 = msg[15:8];
  assign b2 = msg[23:16];
  assign ev = b0[7:4];
  assign ch = b0[3:0];

  assign syx_match = msg[71:64] >= 8'd8 && b0 == lmmd_pkg::SYX_START && b1 == 8'h00 &&
                     b2 == 8'h00 && msg[31:24] == lmmd_pkg::SYX_UNIV &&
                     msg[39:32] == lmmd_pkg::SYX_FAMILY && msg[47:40] == 8'h00;
  assign syx_lay = msg[55:48] == 8'h00 && msg[63:56] == 8'h00;
  assign syx_ack = msg[55:48] == lmmd_pkg::SYX_ACK && msg[63:56] == lmmd_pkg::SYX_END;

  // Decode the latched message into a cell run, a reply, or neither
  always_comb begin
    d_col   = 5'd0;
    d_row   = 5'd0;
    d_horiz = 1'b0;
    d_multi = 1'b0;
    d_bit   = 1'b0;
    d_hit   = 1'b0;
    d_st    = 2'd0;
    d_cls   = lmmd_pkg::CLS_NONE;
    if (ev == lmmd_pkg::EV_NOTE_OFF || ev == lmmd_pkg::EV_NOTE_ON) begin
      if (ev == lmmd_pkg::EV_NOTE_OFF || b2 == 8'h00) d_st = 2'd0;
      else if (b2 < 8'h40) d_st = 2'd1;
      else if (b2 < 8'h60) d_st = 2'd2;
      else d_st = 2'd3;
      d_hit = 1'b1;
      if (b1 < 8'd16) begin
        d_col = {1'b0, b1[3:0]};
        d_row = {1'b0, ch};
      end else if (b1 == 8'h40) begin
        d_col = lmmd_pkg::XCOL;
        d_row = {1'b0, ch};
      end else if (ch == 4'd0 && b1[7:4] == 4'h6) begin
        d_col = {1'b0, b1[3:0]};
        d_row = lmmd_pkg::XROW;
      end else if (ch == 4'hf && b1 == 8'h60) begin
        d_col = lmmd_pkg::XCOL;
        d_row = lmmd_pkg::XROW;
      end else begin
        d_hit = 1'b0;
      end
      d_cls = d_hit ? lmmd_pkg::CLS_CELLS : lmmd_pkg::CLS_READY_ONLY;
    end else if (ev == lmmd_pkg::EV_CTRL) begin
      if (b1[7:6] == 2'b00 && (b1[5:4] == 2'b01 || b1[5:4] == 2'b10) && !b1[2]) begin
        d_hit   = 1'b1;
        d_multi = 1'b1;
        d_bit   = b1[5];
        d_horiz = !b1[3];
        if (d_horiz) begin
          d_col = {1'b0, b1[1], 3'b000};
          d_row = {1'b0, ch};
        end else begin
          d_col = {1'b0, ch};
          d_row = {1'b0, b1[1], 3'b000};
        end
      end else if (b1[7:5] == 3'b010 && !b1[2] && ch == 4'd0) begin
        d_hit   = 1'b1;
        d_multi = 1'b1;
        d_bit   = b1[3];
        d_col   = lmmd_pkg::XCOL + {4'd0, b1[4]};
        d_row   = {1'b0, b1[1], 3'b000};
      end else if (b1[7:4] == 4'h6 && !b1[2]) begin
        d_bit = b1[3];
        if (ch == 4'd0) begin
          d_hit   = 1'b1;
          d_multi = 1'b1;
          d_horiz = 1'b1;
          d_col   = {1'b0, b1[1], 3'b000};
          d_row   = lmmd_pkg::XROW;
        end else if (ch == 4'hf && !b1[1]) begin
          // Corner cell: one colour bit from the pattern's lowest bit
          d_hit = 1'b1;
          d_col = lmmd_pkg::XCOL;
          d_row = lmmd_pkg::XROW;
        end
      end
      d_cls = d_hit ? lmmd_pkg::CLS_CELLS : lmmd_pkg::CLS_READY_ONLY;
    end else if (ev == lmmd_pkg::EV_SYSTEM) begin
      if (syx_match && (syx_lay || syx_ack)) d_cls = lmmd_pkg::CLS_REPLY;
    end
  end

  // Latch message and decoded run
  always_ff @(posedge clk) begin
    if (cmd.accept) msg <= in_data;
    if (cmd.decode) begin
      base_col <= d_col;
      base_row <= d_row;
      horiz    <= d_horiz;
      multi    <= d_multi;
      lay      <= syx_lay;
      if (ev == lmmd_pkg::EV_CTRL) begin
        keep <= d_bit ? 2'b01 : 2'b10;
        mset <= d_bit ? 2'b10 : 2'b01;
        pat  <= {b1[0] | b2[7], b2[6:0]};
      end else begin
        keep <= 2'b00;
        mset <= d_st;
        pat  <= 8'hff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd        <= 1'b0;
      row_count  <= 5'd8;
      ready_flag <= 1'b0;
      clr_cnt    <= '0;
      step       <= 4'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lmmd_pkg::CFG_FORWARD) fwd <= cfg_data[0];
        else row_count <= cfg_data;
      end
      if (cmd.set_ready) ready_flag <= 1'b1;
      if (cmd.clear_wr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.decode) step <= 4'd0;
      else if (cmd.cell_wr || cmd.rep_emit) step <= step + 4'd1;
    end
  end

  // Current cell and the forwarding mask of the whole run
  logic [4:0] cur_col, cur_row;
  logic [7:0] emit_mask, later;
  logic       cur_ok, cur_emit;
  logic [1:0] cur_set, rdata, new_st;
  logic [lmmd_pkg::ADDR_W-1:0] cur_addr;

  assign cur_col = base_col + (horiz ? {2'b00, step[2:0]} : 5'd0);
  assign cur_row = base_row + (horiz ? 5'd0 : {2'b00, step[2:0]});
  assign cur_ok  = cell_ok(cur_col, cur_row);
  assign cur_set = pat[step[2:0]] ? mset : 2'b00;
  assign cur_addr = {cur_col, 4'b0000} + {4'b0000, cur_col} + {4'b0000, cur_row};

  always_comb begin
    logic [4:0] c, r;
    for (int j = 0; j < 8; j++) begin
      c = base_col + (horiz ? 5'(j) : 5'd0);
      r = base_row + (horiz ? 5'd0 : 5'(j));
      emit_mask[j] = fwd && cell_ok(c, r) && (j == 0 || multi) &&
                     !(c >= lmmd_pkg::XCOL && r == lmmd_pkg::XROW);
    end
  end

  assign cur_emit = emit_mask[step[2:0]];
  assign later    = (emit_mask >> step[2:0]) >> 1;
  assign new_st   = (rdata & keep) | cur_set;

  lmmd_ram #(.WIDTH(2), .DEPTH(lmmd_pkg::STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.clear_wr || (cmd.cell_wr && cur_ok)),
    .waddr (cmd.clear_wr ? clr_cnt : cur_addr),
    .wdata (cmd.clear_wr ? 2'b00 : new_st),
    .raddr (cur_addr),
    .rdata (rdata)
  );

  // Status
  assign sts.clear_done = clr_cnt == CLR_LAST;
  assign sts.cls        = d_cls;
  assign sts.cell_last  = !multi || step[2:0] == 3'd7;
  assign sts.cell_emit  = cur_emit;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.rep_last   = lay ? step == 4'd13 : step == 4'd8;

  // Output word register
  logic load_cell;
  assign load_cell = cmd.cell_wr && cur_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_cell || cmd.rep_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_cell) begin
      out_last <= !multi || later == 8'd0;
      if (cur_col < lmmd_pkg::XCOL && cur_row < lmmd_pkg::XROW) begin
        out_kind <= lmmd_pkg::KIND_GRID;
        out_data <= {5'd0, ready_flag, 8'h00, new_st, cur_row[3:0], cur_col[3:0]};
      end else if (cur_row < lmmd_pkg::XROW) begin
        out_kind <= lmmd_pkg::KIND_XCOL;
        out_data <= {5'd0, ready_flag, 8'h00, new_st, cur_row[3:0], 3'b000, cur_col[0]};
      end else begin
        out_kind <= lmmd_pkg::KIND_XROW;
        out_data <= {5'd0, ready_flag, 8'h00, new_st, 4'd0, cur_col[3:0]};
      end
    end else if (cmd.rep_emit) begin
      out_last <= sts.rep_last;
      out_kind <= lmmd_pkg::KIND_REPLY;
      out_data <= {5'd0, ready_flag, rep_byte(step, lay, row_count), 10'd0};
    end
  end

endmodule

// ===== design/lmmd_checker.sv =====
module lmmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // No new message while a run is unfinished
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during an unfinished run");

  // One message at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after a message");

  // A reply always ends with the end marker
  a_reply_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser == lmmd_pkg::KIND_REPLY
      |-> m_axis_tdata[17:10] == lmmd_pkg::SYX_END)
    else $error("reply did not end with end marker");

endmodule

bind led_matrix_midi_decoder_top lmmd_checker u_lmmd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
